[sv/hhx_pkg.sv]
// Shared types, constants and helpers for the HTTP host extract parser.
// Used by every module of the block; depends on nothing else.
package hhx_pkg;

	// Default capture limit in bytes; bytes beyond it are ignored.
	localparam int MAX_FRAME_DEF = 1024;

	localparam int ETH_LEN       = 14;
	localparam int ETYPE_HI_POS  = 12;
	localparam int ETYPE_LO_POS  = 13;
	localparam int IP_PROTO_POS  = ETH_LEN + 9;
	localparam int TCP_DOFF_REL  = 12;
	localparam int PREFIX_LEN    = 6;
	localparam int MIN_OFFSET    = 6;

	localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
	localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
	localparam logic [7:0] PROTO_TCP     = 8'h06;
	localparam logic [7:0] CHAR_CR       = 8'h0D;
	localparam logic [3:0] DOFF_MIN      = 4'd5;

	localparam logic [7:0] HOST_OFFSET_RST = 8'd21;
	localparam logic [7:0] HOST_LIMIT_RST  = 8'd200;

	// Result queue between the parser and the output port.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [0:0] {
		REG_HOST_OFFSET = 1'b0,
		REG_HOST_LIMIT  = 1'b1
	} reg_idx_t;

	typedef enum logic [5:0] {
		PH_ETH    = 6'b000001,
		PH_IP     = 6'b000010,
		PH_PREFIX = 6'b000100,
		PH_GAP    = 6'b001000,
		PH_HOST   = 6'b010000,
		PH_SKIP   = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0] host_offset;
		logic [7:0] host_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0] host_byte;
		logic       record_end;
	} res_t;

	// Up to two results per input byte, slot 0 first.
	typedef struct packed {
		logic [1:0]      cnt;
		res_t [1:0]      item;
	} push_t;

	// Characters of the request line prefix "GET / ".
	function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = 8'h47;
			3'd1:    c = 8'h45;
			3'd2:    c = 8'h54;
			3'd3:    c = 8'h20;
			3'd4:    c = 8'h2F;
			3'd5:    c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

[sv/hhx_cfg_regs.sv]
// APB-style register file holding the host offset and host limit.
// Depends on hhx_pkg for the register indexes and reset values.
module hhx_cfg_regs (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	output hhx_pkg::cfg_t cfg
);
	import hhx_pkg::*;

	logic [7:0] host_offset_q;
	logic [7:0] host_limit_q;
	reg_idx_t   idx;
	logic       wr_en;

	assign idx    = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_offset_q <= HOST_OFFSET_RST;
			host_limit_q  <= HOST_LIMIT_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_HOST_OFFSET: host_offset_q <= pwdata[7:0];
				REG_HOST_LIMIT:  host_limit_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_HOST_OFFSET: prdata = {24'd0, host_offset_q};
			REG_HOST_LIMIT:  prdata = {24'd0, host_limit_q};
			default:         prdata = '0;
		endcase
	end

	assign cfg.host_offset = host_offset_q;
	assign cfg.host_limit  = host_limit_q;

endmodule

[sv/hhx_parse.sv]
// Frame parser: input register, header walk and host byte selection.
// Depends on hhx_pkg; hands up to two results per byte to the result queue.
module hhx_parse #(
	parameter int MAX_FRAME = hhx_pkg::MAX_FRAME_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,
	input  logic          s_tlast,
	input  hhx_pkg::cfg_t cfg,
	input  logic          room,
	output hhx_pkg::push_t push
);
	import hhx_pkg::*;

	localparam int POS_W = $clog2(MAX_FRAME + 1);
	// Compare width: holds the frame position and payload start plus offset.
	localparam int CW    = (POS_W > 10) ? POS_W : 10;

	logic             s1_valid;
	logic [7:0]       byte_s1;
	logic             last_s1;

	logic [POS_W-1:0] pos_q,     pos_n;
	phase_t           phase_q,   phase_n;
	logic [7:0]       eth_hi_q,  eth_hi_n;
	logic [5:0]       ihl_q,     ihl_n;
	logic [7:0]       ps_q,      ps_n;
	logic             matched_q, matched_n;
	logic [7:0]       cnt_q,     cnt_n;

	logic             process;
	logic             in_range;
	logic [CW-1:0]    pos_c;
	logic [CW-1:0]    idx;
	logic [7:0]       off;
	logic [7:0]       doff_bytes;
	logic [7:0]       cnt_inc;
	logic             byte_emit;
	logic             end_host;
	logic             end_last;

	assign process  = s1_valid & room;
	assign s_tready = ~s1_valid | room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			s1_valid <= 1'b1;
		end else if (process) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	assign in_range   = pos_q < POS_W'(MAX_FRAME);
	assign pos_c      = CW'(pos_q);
	assign idx        = pos_c - CW'(ps_q);
	assign off        = (cfg.host_offset < 8'(MIN_OFFSET)) ? 8'(MIN_OFFSET) : cfg.host_offset;
	assign doff_bytes = {2'b00, byte_s1[7:4], 2'b00};
	assign cnt_inc    = cnt_q + 8'd1;

	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		eth_hi_n  = eth_hi_q;
		ihl_n     = ihl_q;
		ps_n      = ps_q;
		matched_n = matched_q;
		cnt_n     = cnt_q;
		byte_emit = 1'b0;
		end_host  = 1'b0;
		end_last  = 1'b0;

		if (in_range) begin
			unique case (phase_q)
				PH_ETH: begin
					if (pos_q == POS_W'(ETYPE_HI_POS)) begin
						eth_hi_n = byte_s1;
					end else if (pos_q == POS_W'(ETYPE_LO_POS)) begin
						phase_n = (eth_hi_q == ETYPE_IPV4_HI && byte_s1 == ETYPE_IPV4_LO)
							? PH_IP : PH_SKIP;
					end
				end
				PH_IP: begin
					if (pos_q == POS_W'(ETH_LEN)) begin
						ihl_n = {byte_s1[3:0], 2'b00};
					end else if (pos_q == POS_W'(IP_PROTO_POS)) begin
						if (byte_s1 != PROTO_TCP) begin
							phase_n = PH_SKIP;
						end
					end else if (pos_c == CW'(ETH_LEN + TCP_DOFF_REL) + CW'(ihl_q)) begin
						if (byte_s1[7:4] < DOFF_MIN) begin
							phase_n = PH_SKIP;
						end else begin
							ps_n    = 8'(ETH_LEN) + {2'b00, ihl_q} + doff_bytes;
							phase_n = PH_PREFIX;
						end
					end
				end
				PH_PREFIX: begin
					if (pos_c >= CW'(ps_q)) begin
						if (idx >= CW'(PREFIX_LEN) || byte_s1 != prefix_byte(idx[2:0])) begin
							phase_n = PH_SKIP;
						end else if (idx == CW'(PREFIX_LEN - 1)) begin
							matched_n = 1'b1;
							phase_n   = PH_GAP;
						end
					end
				end
				PH_GAP: begin
					if (pos_c >= CW'(ps_q) + CW'(off)) begin
						phase_n = PH_HOST;
					end
				end
				PH_HOST, PH_SKIP: ;
				default: ;
			endcase

			// The host phase acts on the same byte that opened it.
			if (phase_n == PH_HOST) begin
				if (cnt_q >= cfg.host_limit || byte_s1 == CHAR_CR) begin
					end_host = 1'b1;
					phase_n  = PH_SKIP;
				end else begin
					byte_emit = 1'b1;
					cnt_n     = cnt_inc;
					if (cnt_inc >= cfg.host_limit) begin
						end_host = 1'b1;
						phase_n  = PH_SKIP;
					end
				end
			end
		end

		if (last_s1) begin
			if (matched_n && (phase_n == PH_GAP || phase_n == PH_HOST)) begin
				end_last = 1'b1;
			end
			pos_n     = '0;
			phase_n   = PH_ETH;
			eth_hi_n  = '0;
			ihl_n     = '0;
			ps_n      = '0;
			matched_n = 1'b0;
			cnt_n     = '0;
		end else if (in_range) begin
			pos_n = pos_q + POS_W'(1);
		end
	end

	always_comb begin
		push.item[0].host_byte  = byte_emit ? byte_s1 : 8'd0;
		push.item[0].record_end = ~byte_emit;
		push.item[1].host_byte  = 8'd0;
		push.item[1].record_end = 1'b1;
		push.cnt = process ? (2'(byte_emit) + 2'(end_host | end_last)) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			phase_q   <= PH_ETH;
			eth_hi_q  <= '0;
			ihl_q     <= '0;
			ps_q      <= '0;
			matched_q <= 1'b0;
			cnt_q     <= '0;
		end else if (process) begin
			pos_q     <= pos_n;
			phase_q   <= phase_n;
			eth_hi_q  <= eth_hi_n;
			ihl_q     <= ihl_n;
			ps_q      <= ps_n;
			matched_q <= matched_n;
			cnt_q     <= cnt_n;
		end
	end

	// The position counter saturates at the capture limit.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_FRAME))
		else $error("frame position beyond capture limit");

	// A matched prefix only lives in the gap, host or skip phases.
	a_matched_phase: assert property (@(posedge clk) disable iff (!arst_n)
		matched_q |-> (phase_q == PH_GAP || phase_q == PH_HOST || phase_q == PH_SKIP))
		else $error("prefix flag set in a header phase");

	// Closing a record leaves the host phase for good.
	a_end_leaves_host: assert property (@(posedge clk) disable iff (!arst_n)
		(process && (end_host || end_last)) |=> (phase_q == PH_SKIP || phase_q == PH_ETH))
		else $error("record closed but host phase still open");

	// Nothing is handed on unless the queue has room for a full pair.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> room)
		else $error("results pushed without queue room");

endmodule

[sv/hhx_out_fifo.sv]
// Four-entry result queue taking up to two results a cycle, one out a cycle while m_tready is high.
// Depends on hhx_pkg for the result types and queue sizing.
module hhx_out_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  hhx_pkg::push_t push,
	output logic           room,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,
	output logic           m_tlast
);
	import hhx_pkg::*;

	res_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;
	logic [FIFO_PTR_W-1:0] wr_ptr_1;

	assign pop      = m_tvalid & m_tready;
	assign room     = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
	assign m_tvalid = count_q != '0;
	assign m_tdata  = mem_q[rd_ptr_q].host_byte;
	assign m_tlast  = mem_q[rd_ptr_q].record_end;
	assign wr_ptr_1 = wr_ptr_q + FIFO_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.item[0];
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr_1] <= push.item[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.cnt);
			rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(pop);
			count_q  <= count_q + FIFO_CNT_W'(push.cnt) - FIFO_CNT_W'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("result queue overfilled");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.cnt == 2'd0) |=> count_q == $past(count_q) - FIFO_CNT_W'(1))
		else $error("queue count lost track of a transfer");

	a_push_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt == 2'd2 && !pop) |=> count_q == $past(count_q) + FIFO_CNT_W'(2))
		else $error("paired push not counted");

endmodule

[sv/http_host_extract_parser.sv]
// HTTP host extract parser: top level joining registers, parser and result queue.
// Depends on hhx_pkg, hhx_cfg_regs, hhx_parse and hhx_out_fifo.
//
// The block takes one Ethernet frame byte per clock and keeps that rate for as
// long as the result side drains. Each byte passes an input register and is
// parsed from that register when the result queue has room for a full pair. A
// byte may give two results (the last host byte and its end record), which go
// into the four-entry result queue that sends one transfer per cycle while
// m_tready is high; input is held back only while that queue cannot take a
// full pair. No clearing pass is needed after reset.
module http_host_extract_parser #(
	parameter int MAX_FRAME = hhx_pkg::MAX_FRAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] frame_byte
	input  logic        s_tlast,   // frame_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] host_byte
	output logic        m_tlast,   // record_end
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import hhx_pkg::*;

	cfg_t  cfg;
	push_t push;
	logic  room;

	hhx_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hhx_parse #(
		.MAX_FRAME (MAX_FRAME)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.cfg      (cfg),
		.room     (room),
		.push     (push)
	);

	hhx_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
